// ===== sv/ofb_pkg.sv =====
package ofb_pkg;

    localparam int IN_WIDTH_DEF = 32;
    localparam int OUT_FRAC_DEF = 30;
    localparam int IN_FRAC      = 24;
    localparam int OUT_W        = 32;
    localparam longint OUT_MAX  = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;

    localparam int DIM_W      = 2;
    localparam int TOL_W      = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam logic [DIM_W-1:0] DIM_2D    = 2'd2;
    localparam logic [DIM_W-1:0] DIM_RST   = 2'd3;
    localparam logic             GIVEN_RST = 1'b0;
    localparam logic [TOL_W-1:0] TOL_RST   = 31'd17;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIMENSION = 2'd0,
        REG_LAST_AXIS = 2'd1,
        REG_ORTH_TOL  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             two_d;
        logic             given;
        logic [TOL_W-1:0] tol;
    } ofb_cfg_t;

endpackage

// ===== sv/ofb_norm.sv =====
module ofb_norm
    import ofb_pkg::*;
#(
    parameter int IN_WIDTH          = IN_WIDTH_DEF,
    parameter int OUT_FRACTION_BITS = OUT_FRAC_DEF
)(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [IN_WIDTH-1:0]          v [3],
    output logic signed [OUT_FRACTION_BITS+1:0] u [3],
    output logic                                zero
);

    localparam int W  = IN_WIDTH;
    localparam int F  = OUT_FRACTION_BITS;
    localparam int UW = F + 2;
    localparam int SW = 2 * W + 1;
    localparam int PW = 2 * W + 2;
    localparam int NQ = 2 * F + 3;
    localparam int NS = F + 2;
    localparam int QW = 2 * NS;
    localparam int RW = NS + 3;
    localparam logic [UW-1:0] ONE_U = UW'(1) << F;

    // squares and magnitude
    logic [W-1:0]   mag_next [3];
    logic [2*W-1:0] sq_next [3];
    logic [2*W-1:0] sq_reg [3];
    logic [2:0]     sg1_reg;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            mag_next[c] = v[c][W-1] ? W'(-v[c]) : W'(v[c]);
            sq_next[c]  = (2*W)'(mag_next[c]) * (2*W)'(mag_next[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c]  <= sq_next[c];
                sg1_reg[c] <= v[c][W-1];
            end
        end
    end

    // sum of squares
    logic [SW-1:0]  s_next;
    logic [SW-1:0]  s_reg;
    logic           z2_reg;
    logic [2*W-1:0] msq_reg [3];
    logic [2:0]     sg2_reg;

    assign s_next = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg   <= s_next;
            z2_reg  <= (s_next == '0);
            msq_reg <= sq_reg;
            sg2_reg <= sg1_reg;
        end
    end

    // restoring divide: floor(m^2 * 2^(2F+2) / S), one quotient bit per stage
    logic [PW-1:0] dp_reg [NQ][3];
    logic [NQ-1:0] dq_reg [NQ][3];
    logic [SW-1:0] ds_reg [NQ];
    logic          dz_reg [NQ];
    logic [2:0]    dsg_reg [NQ];

    for (genvar k = 0; k < NQ; k++)
    begin : g_div
        logic [SW-1:0] s_in;
        logic          z_in;
        logic [2:0]    sg_in;

        if (k == 0)
        begin : g_head
            assign s_in  = s_reg;
            assign z_in  = z2_reg;
            assign sg_in = sg2_reg;
        end
        else
        begin : g_body
            assign s_in  = ds_reg[k-1];
            assign z_in  = dz_reg[k-1];
            assign sg_in = dsg_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ds_reg[k]  <= s_in;
                dz_reg[k]  <= z_in;
                dsg_reg[k] <= sg_in;
            end
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_lane
            logic [PW-1:0] p_in;
            logic [NQ-1:0] q_in;
            logic          b_in;
            logic [PW:0]   t;
            logic [PW-1:0] p_next;
            logic [NQ-1:0] q_next;

            if (k == 0)
            begin : g_head
                assign p_in = PW'(msq_reg[c] >> 1);
                assign q_in = '0;
                assign b_in = msq_reg[c][0];
            end
            else
            begin : g_body
                assign p_in = dp_reg[k-1][c];
                assign q_in = dq_reg[k-1][c];
                assign b_in = 1'b0;
            end

            assign t = {p_in, b_in};

            always_comb
            begin
                if (t >= (PW+1)'(s_in))
                begin
                    p_next = PW'(t - (PW+1)'(s_in));
                    q_next = {q_in[NQ-2:0], 1'b1};
                end
                else
                begin
                    p_next = PW'(t);
                    q_next = {q_in[NQ-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dp_reg[k][c] <= p_next;
                    dq_reg[k][c] <= q_next;
                end
            end
        end
    end

    // digit square root of the quotient, one root bit per stage
    logic [NS-1:0] rr_reg [NS][3];
    logic [RW-1:0] rm_reg [NS][3];
    logic [QW-1:0] rq_reg [NS][3];
    logic          rz_reg [NS];
    logic [2:0]    rsg_reg [NS];

    for (genvar j = 0; j < NS; j++)
    begin : g_sqrt
        logic       z_in;
        logic [2:0] sg_in;

        if (j == 0)
        begin : g_head
            assign z_in  = dz_reg[NQ-1];
            assign sg_in = dsg_reg[NQ-1];
        end
        else
        begin : g_body
            assign z_in  = rz_reg[j-1];
            assign sg_in = rsg_reg[j-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rz_reg[j]  <= z_in;
                rsg_reg[j] <= sg_in;
            end
        end

        for (genvar c = 0; c < 3; c++)
        begin : g_lane
            logic [NS-1:0] root_in;
            logic [RW-1:0] rem_in;
            logic [QW-1:0] qs_in;
            logic [RW+1:0] rem2;
            logic [RW+1:0] trial;
            logic [NS-1:0] root_next;
            logic [RW-1:0] rem_next;

            if (j == 0)
            begin : g_head
                assign root_in = '0;
                assign rem_in  = '0;
                assign qs_in   = QW'(dq_reg[NQ-1][c]);
            end
            else
            begin : g_body
                assign root_in = rr_reg[j-1][c];
                assign rem_in  = rm_reg[j-1][c];
                assign qs_in   = rq_reg[j-1][c];
            end

            assign rem2  = {rem_in, qs_in[QW-1-2*j -: 2]};
            assign trial = (RW+2)'({root_in, 2'b01});

            always_comb
            begin
                if (rem2 >= trial)
                begin
                    rem_next  = RW'(rem2 - trial);
                    root_next = {root_in[NS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = RW'(rem2);
                    root_next = {root_in[NS-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rr_reg[j][c] <= root_next;
                    rm_reg[j][c] <= rem_next;
                    rq_reg[j][c] <= qs_in;
                end
            end
        end
    end

    // largest odd t <= root gives q = (root + 1) / 2, capped at one
    logic signed [UW-1:0] u_reg [3];
    logic                 zero_reg;

    for (genvar c = 0; c < 3; c++)
    begin : g_fin
        logic [UW:0]          tq;
        logic [UW-1:0]        qm;
        logic signed [UW-1:0] u_next;

        assign tq = ({1'b0, rr_reg[NS-1][c]} + (UW+1)'(1)) >> 1;
        assign qm = (tq > (UW+1)'(ONE_U)) ? ONE_U : UW'(tq);

        always_comb
        begin
            if (rz_reg[NS-1])
                u_next = '0;
            else if (rsg_reg[NS-1][c])
                u_next = -$signed(qm);
            else
                u_next = $signed(qm);
        end

        always_ff @(posedge clk)
        begin
            if (en)
                u_reg[c] <= u_next;
        end

        assign u[c] = u_reg[c];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            zero_reg <= rz_reg[NS-1];
    end

    assign zero = zero_reg;

endmodule

// ===== sv/ofb_post.sv =====
module ofb_post
    import ofb_pkg::*;
#(
    parameter int IN_WIDTH          = IN_WIDTH_DEF,
    parameter int OUT_FRACTION_BITS = OUT_FRAC_DEF
)(
    input  logic                                clk,
    input  logic                                en,
    input  ofb_cfg_t                            cfg,
    input  logic signed [OUT_FRACTION_BITS+1:0] ux [3],
    input  logic signed [OUT_FRACTION_BITS+1:0] uy [3],
    input  logic signed [IN_WIDTH-1:0]          yv [3],
    input  logic signed [IN_WIDTH-1:0]          zv [3],
    input  logic                                zl_in,
    output logic [OUT_W-1:0]                    m [9],
    output logic                                zero_length,
    output logic                                not_orthogonal
);

    localparam int W     = IN_WIDTH;
    localparam int F     = OUT_FRACTION_BITS;
    localparam int UW    = F + 2;
    localparam int BW    = UW + W;
    localparam int CA    = 2 * UW + 33;
    localparam int CB    = BW + 33;
    localparam int SHA   = 2 * F - IN_FRAC;
    localparam int SAT_W = 2 * UW + W + 8;
    localparam int GS    = (F >= IN_FRAC) ? F - IN_FRAC : 0;
    localparam int RS    = (F < IN_FRAC) ? IN_FRAC - F : 0;
    localparam int RS1   = (RS > 0) ? RS - 1 : 0;

    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(OUT_MAX);
    localparam logic signed [SAT_W-1:0] SAT_MIN = ~SAT_MAX;
    localparam logic signed [SAT_W-1:0] RND_G   = (RS > 0) ? (SAT_W'(1) <<< RS1) : '0;
    localparam logic signed [SAT_W-1:0] RND_X   = SAT_W'(1) <<< (F - 1);

    function automatic logic [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] a);
        logic [OUT_W-1:0] r;
        if (a > SAT_MAX)
            r = SAT_MAX[OUT_W-1:0];
        else if (a < SAT_MIN)
            r = SAT_MIN[OUT_W-1:0];
        else
            r = a[OUT_W-1:0];
        return r;
    endfunction

    // given axis: Q8.24 to F fraction bits, halves toward plus infinity
    function automatic logic [OUT_W-1:0] g_conv(input logic signed [W-1:0] a);
        logic signed [SAT_W-1:0] e;
        e = SAT_W'(a);
        if (F >= IN_FRAC)
            e = e <<< GS;
        else
            e = (e + RND_G) >>> RS;
        return sat_out(e);
    endfunction

    function automatic logic [OUT_W-1:0] x_conv(input logic signed [SAT_W-1:0] a);
        return sat_out((a + RND_X) >>> F);
    endfunction

    // stage A: products
    logic signed [2*UW-1:0] pa_next [3];
    logic signed [BW-1:0]   pb_next [3];
    logic signed [BW-1:0]   pc_next [3];
    logic signed [2*UW-1:0] px_next [6];

    logic signed [2*UW-1:0] pa_reg [3];
    logic signed [BW-1:0]   pb_reg [3];
    logic signed [BW-1:0]   pc_reg [3];
    logic signed [2*UW-1:0] px_reg [6];
    logic signed [UW-1:0]   ux_reg [3];
    logic signed [UW-1:0]   uy_reg [3];
    logic signed [W-1:0]    y_reg [3];
    logic signed [W-1:0]    z_reg [3];
    logic                   zl_reg;

    always_comb
    begin
        logic signed [W-1:0] wb;
        wb = '0;
        for (int k = 0; k < 3; k++)
        begin
            wb         = cfg.two_d ? yv[k] : zv[k];
            pa_next[k] = (2*UW)'(ux[k]) * (2*UW)'(uy[k]);
            pb_next[k] = BW'(ux[k]) * BW'(wb);
            pc_next[k] = BW'(uy[k]) * BW'(zv[k]);
        end
        px_next[0] = (2*UW)'(ux[1]) * (2*UW)'(uy[2]);
        px_next[1] = (2*UW)'(ux[2]) * (2*UW)'(uy[1]);
        px_next[2] = (2*UW)'(ux[2]) * (2*UW)'(uy[0]);
        px_next[3] = (2*UW)'(ux[0]) * (2*UW)'(uy[2]);
        px_next[4] = (2*UW)'(ux[0]) * (2*UW)'(uy[1]);
        px_next[5] = (2*UW)'(ux[1]) * (2*UW)'(uy[0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
            px_reg <= px_next;
            ux_reg <= ux;
            uy_reg <= uy;
            y_reg  <= yv;
            z_reg  <= zv;
            zl_reg <= zl_in;
        end
    end

    // stage B: dot checks, rescale, saturate
    logic signed [CA-1:0] sa;
    logic signed [CA-1:0] aa;
    logic signed [CB-1:0] sb;
    logic signed [CB-1:0] ab;
    logic signed [CB-1:0] sc;
    logic signed [CB-1:0] ac;
    logic                 exa;
    logic                 exb;
    logic                 exc;
    logic                 no_next;
    logic [OUT_W-1:0]     m_next [9];

    always_comb
    begin
        sa  = CA'(pa_reg[0]) + CA'(pa_reg[1]) + CA'(pa_reg[2]);
        sb  = CB'(pb_reg[0]) + CB'(pb_reg[1]) + CB'(pb_reg[2]);
        sc  = CB'(pc_reg[0]) + CB'(pc_reg[1]) + CB'(pc_reg[2]);
        aa  = sa[CA-1] ? -sa : sa;
        ab  = sb[CB-1] ? -sb : sb;
        ac  = sc[CB-1] ? -sc : sc;
        exa = aa > (CA'(cfg.tol) << SHA);
        exb = ab > (CB'(cfg.tol) << F);
        exc = ac > (CB'(cfg.tol) << F);

        if (cfg.two_d)
            no_next = cfg.given && exb;
        else
            no_next = exa || (cfg.given && (exb || exc));

        for (int k = 0; k < 9; k++)
            m_next[k] = '0;

        if (cfg.two_d)
        begin
            m_next[0] = sat_out(SAT_W'(ux_reg[0]));
            m_next[1] = sat_out(SAT_W'(ux_reg[1]));
            if (cfg.given)
            begin
                m_next[3] = g_conv(y_reg[0]);
                m_next[4] = g_conv(y_reg[1]);
            end
            else
            begin
                m_next[3] = sat_out(-SAT_W'(ux_reg[1]));
                m_next[4] = sat_out(SAT_W'(ux_reg[0]));
            end
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_next[k]     = sat_out(SAT_W'(ux_reg[k]));
                m_next[3 + k] = sat_out(SAT_W'(uy_reg[k]));
            end
            if (cfg.given)
            begin
                for (int k = 0; k < 3; k++)
                    m_next[6 + k] = g_conv(z_reg[k]);
            end
            else
            begin
                m_next[6] = x_conv(SAT_W'(px_reg[0]) - SAT_W'(px_reg[1]));
                m_next[7] = x_conv(SAT_W'(px_reg[2]) - SAT_W'(px_reg[3]));
                m_next[8] = x_conv(SAT_W'(px_reg[4]) - SAT_W'(px_reg[5]));
            end
        end

        // zero-length vector: drop the whole matrix
        if (zl_reg)
        begin
            for (int k = 0; k < 9; k++)
                m_next[k] = '0;
        end
    end

    logic [OUT_W-1:0] m_reg [9];
    logic             zo_reg;
    logic             no_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg  <= m_next;
            zo_reg <= zl_reg;
            no_reg <= no_next;
        end
    end

    assign m              = m_reg;
    assign zero_length    = zo_reg;
    assign not_orthogonal = no_reg;

endmodule

// ===== sv/orthonormal_frame_builder.sv =====
// channel | direction | handshake             | payload
// --------+-----------+-----------------------+---------------------------------------
// cfg     | in        | cfg_we                | cfg_index, cfg_data
// in      | in        | in_valid / in_stall   | x_first .. z_third
// out     | out       | out_valid / out_stall | m00 .. m22, zero_length, not_orthogonal
//
// One beat enters per cycle while the output is not stalled.
// The pipeline is the per-component restoring divider (2F+3 stages) followed by
// the digit square root (F+2 stages), plus squares, sum, product and output stages.
// Reset loads the configuration registers with their defaults and clears the valid line; payload is not reset.
// A stalled beat at the output freezes the whole pipeline; in_stall follows it.
module orthonormal_frame_builder
    import ofb_pkg::*;
#(
    parameter int IN_WIDTH          = IN_WIDTH_DEF,
    parameter int OUT_FRACTION_BITS = OUT_FRAC_DEF
)(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [IN_WIDTH-1:0] x_first,
    input  logic signed [IN_WIDTH-1:0] x_second,
    input  logic signed [IN_WIDTH-1:0] x_third,
    input  logic signed [IN_WIDTH-1:0] y_first,
    input  logic signed [IN_WIDTH-1:0] y_second,
    input  logic signed [IN_WIDTH-1:0] y_third,
    input  logic signed [IN_WIDTH-1:0] z_first,
    input  logic signed [IN_WIDTH-1:0] z_second,
    input  logic signed [IN_WIDTH-1:0] z_third,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [OUT_W-1:0]    m00,
    output logic signed [OUT_W-1:0]    m10,
    output logic signed [OUT_W-1:0]    m20,
    output logic signed [OUT_W-1:0]    m01,
    output logic signed [OUT_W-1:0]    m11,
    output logic signed [OUT_W-1:0]    m21,
    output logic signed [OUT_W-1:0]    m02,
    output logic signed [OUT_W-1:0]    m12,
    output logic signed [OUT_W-1:0]    m22,
    output logic                       zero_length,
    output logic                       not_orthogonal
);

    localparam int W     = IN_WIDTH;
    localparam int F     = OUT_FRACTION_BITS;
    localparam int UW    = F + 2;
    localparam int LAT_N = 3 * F + 8;
    localparam int LAT   = LAT_N + 2;
    localparam int DW    = 6 * W;

    // configuration
    logic [DIM_W-1:0] dim_reg;
    logic             given_reg;
    logic [TOL_W-1:0] tol_reg;
    ofb_cfg_t         cfg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg   <= DIM_RST;
            given_reg <= GIVEN_RST;
            tol_reg   <= TOL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DIMENSION: dim_reg   <= cfg_data[DIM_W-1:0];
                REG_LAST_AXIS: given_reg <= cfg_data[0];
                REG_ORTH_TOL:  tol_reg   <= cfg_data[TOL_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg.two_d = (dim_reg == DIM_2D);
    assign cfg.given = given_reg;
    assign cfg.tol   = tol_reg;

    // valid line and global advance
    logic [LAT-1:0] vld_reg;
    logic           pipe_en;
    logic           in_acc;

    assign out_valid = vld_reg[LAT-1];
    assign pipe_en   = !(out_valid && out_stall);
    assign in_stall  = !pipe_en;
    assign in_acc    = in_valid && pipe_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pipe_en)
            vld_reg <= {vld_reg[LAT-2:0], in_acc};
    end

    // normalizers
    logic signed [W-1:0]  xv [3];
    logic signed [W-1:0]  yv_in [3];
    logic signed [UW-1:0] ux [3];
    logic signed [UW-1:0] uy [3];
    logic                 zx;
    logic                 zy;

    assign xv[0]    = x_first;
    assign xv[1]    = x_second;
    assign xv[2]    = cfg.two_d ? '0 : x_third;
    assign yv_in[0] = y_first;
    assign yv_in[1] = y_second;
    assign yv_in[2] = y_third;

    ofb_norm #(
        .IN_WIDTH          (IN_WIDTH),
        .OUT_FRACTION_BITS (OUT_FRACTION_BITS)
    ) u_norm_x (
        .clk  (clk),
        .en   (pipe_en),
        .v    (xv),
        .u    (ux),
        .zero (zx)
    );

    ofb_norm #(
        .IN_WIDTH          (IN_WIDTH),
        .OUT_FRACTION_BITS (OUT_FRACTION_BITS)
    ) u_norm_y (
        .clk  (clk),
        .en   (pipe_en),
        .v    (yv_in),
        .u    (uy),
        .zero (zy)
    );

    // raw Y and Z ride alongside the normalizers
    logic [DW-1:0] dly_reg [LAT_N];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            dly_reg[0] <= {y_first, y_second, y_third, z_first, z_second, z_third};
            for (int k = 1; k < LAT_N; k++)
                dly_reg[k] <= dly_reg[k-1];
        end
    end

    logic signed [W-1:0] yd [3];
    logic signed [W-1:0] zd [3];
    logic                zl;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            yd[k] = $signed(dly_reg[LAT_N-1][(6-k)*W-1 -: W]);
            zd[k] = $signed(dly_reg[LAT_N-1][(3-k)*W-1 -: W]);
        end
    end

    assign zl = cfg.two_d ? zx : (zx || zy);

    logic [OUT_W-1:0] m [9];

    ofb_post #(
        .IN_WIDTH          (IN_WIDTH),
        .OUT_FRACTION_BITS (OUT_FRACTION_BITS)
    ) u_post (
        .clk            (clk),
        .en             (pipe_en),
        .cfg            (cfg),
        .ux             (ux),
        .uy             (uy),
        .yv             (yd),
        .zv             (zd),
        .zl_in          (zl),
        .m              (m),
        .zero_length    (zero_length),
        .not_orthogonal (not_orthogonal)
    );

    assign m00 = $signed(m[0]);
    assign m10 = $signed(m[1]);
    assign m20 = $signed(m[2]);
    assign m01 = $signed(m[3]);
    assign m11 = $signed(m[4]);
    assign m21 = $signed(m[5]);
    assign m02 = $signed(m[6]);
    assign m12 = $signed(m[7]);
    assign m22 = $signed(m[8]);

`ifndef ASSERT_OFF
    a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_length |-> m00 == 0 && m10 == 0 && m20 == 0 && m01 == 0 &&
            m11 == 0 && m21 == 0 && m02 == 0 && m12 == 0 && m22 == 0)
        else $error("zero-length beat carries a nonzero matrix");

    a_two_d_unused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dim_reg == DIM_2D |-> m20 == 0 && m21 == 0 && m02 == 0 &&
            m12 == 0 && m22 == 0)
        else $error("2D frame has nonzero third row or column");

    a_valid_lands: assert property (@(posedge clk) disable iff (!rst_n)
        pipe_en && vld_reg[LAT-2] |=> out_valid)
        else $error("beat lost at the output stage");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ofb_pkg::*;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [31:0] comp_t;

    typedef struct {
        logic [31:0] m [9];
        logic        zl;
        logic        no;
    } frame_t;

    localparam int   FB        = 30;
    localparam int   DRAIN     = 130;
    localparam int   LIMIT     = 600000;
    localparam comp_t ONE      = 32'sh0100_0000;
    localparam comp_t CMAX     = 32'sh7FFF_FFFF;
    localparam comp_t CMIN     = 32'sh8000_0000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [DIM_W-1:0] DIM_ZERO = 2'd0;
    localparam logic [DIM_W-1:0] DIM_ONE  = 2'd1;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    comp_t x_first, x_second, x_third, y_first, y_second, y_third;
    comp_t z_first, z_second, z_third;
    logic out_valid;
    logic out_stall;
    comp_t m00, m10, m20, m01, m11, m21, m02, m12, m22;
    logic zero_length;
    logic not_orthogonal;

    logic [DIM_W-1:0] frame_dim;
    logic             frame_given;
    logic [TOL_W-1:0] frame_tol;

    frame_t frames_pending [$];
    int     mismatches;
    int     cycles;
    bit     no_gaps;

    orthonormal_frame_builder u_dut (.*);

    always #4 clk = ~clk;

    // ---------------- predictor ----------------
    function automatic logic [31:0] to_out(wide_t a, int frac);
        int    s;
        wide_t r;
        s = frac - FB;
        if (s <= 0)
            r = a <<< (-s);
        else
            r = (a + (wide_t'(1) <<< (s - 1))) >>> s;
        if (r > wide_t'(CMAX))
            return CMAX;
        if (r < wide_t'(CMIN))
            return CMIN;
        return r[31:0];
    endfunction

    function automatic logic unit_vec(input wide_t v [3], input int n, output wide_t u [3]);
        wide_t s, m, rhs, t, q, cand, lim;
        s = 0;
        lim = wide_t'(1) <<< FB;
        for (int i = 0; i < 3; i++)
            u[i] = 0;
        for (int i = 0; i < n; i++)
            s = s + v[i] * v[i];
        if (s == 0)
            return 1'b1;
        for (int i = 0; i < n; i++)
        begin
            m = v[i] < 0 ? -v[i] : v[i];
            rhs = (m * m) <<< (2 * FB + 2);
            q = 0;
            for (int b = FB; b >= 0; b--)
            begin
                cand = q | (wide_t'(1) <<< b);
                if (cand <= lim)
                begin
                    t = 2 * cand - 1;
                    if (t * t * s <= rhs)
                        q = cand;
                end
            end
            u[i] = v[i] < 0 ? -q : q;
        end
        return 1'b0;
    endfunction

    function automatic logic dot_over(wide_t a [3], wide_t b [3], int n, int fab);
        wide_t d;
        d = 0;
        for (int i = 0; i < n; i++)
            d = d + a[i] * b[i];
        if (d < 0)
            d = -d;
        return (d <<< IN_FRAC) > (wide_t'({1'b0, frame_tol}) <<< fab);
    endfunction

    function automatic frame_t build_frame(comp_t v [9]);
        frame_t f;
        wide_t  x [3], y [3], z [3], ux [3], uy [3];
        logic   zl, no;
        for (int i = 0; i < 3; i++)
        begin
            x[i] = v[i];
            y[i] = v[3 + i];
            z[i] = v[6 + i];
        end
        for (int i = 0; i < 9; i++)
            f.m[i] = '0;
        no = 1'b0;
        if (frame_dim == DIM_2D)
        begin
            zl = unit_vec(x, 2, ux);
            f.m[0] = to_out(ux[0], FB);
            f.m[1] = to_out(ux[1], FB);
            if (frame_given)
            begin
                no = dot_over(ux, y, 2, FB + IN_FRAC);
                f.m[3] = to_out(y[0], IN_FRAC);
                f.m[4] = to_out(y[1], IN_FRAC);
            end
            else
            begin
                f.m[3] = to_out(-ux[1], FB);
                f.m[4] = to_out(ux[0], FB);
            end
        end
        else
        begin
            zl = unit_vec(x, 3, ux);
            zl = unit_vec(y, 3, uy) | zl;
            no = dot_over(ux, uy, 3, 2 * FB);
            for (int i = 0; i < 3; i++)
            begin
                f.m[i] = to_out(ux[i], FB);
                f.m[3 + i] = to_out(uy[i], FB);
            end
            if (frame_given)
            begin
                no = dot_over(ux, z, 3, FB + IN_FRAC) | no;
                no = dot_over(uy, z, 3, FB + IN_FRAC) | no;
                for (int i = 0; i < 3; i++)
                    f.m[6 + i] = to_out(z[i], IN_FRAC);
            end
            else
            begin
                f.m[6] = to_out(ux[1] * uy[2] - ux[2] * uy[1], 2 * FB);
                f.m[7] = to_out(ux[2] * uy[0] - ux[0] * uy[2], 2 * FB);
                f.m[8] = to_out(ux[0] * uy[1] - ux[1] * uy[0], 2 * FB);
            end
        end
        if (zl)
            for (int i = 0; i < 9; i++)
                f.m[i] = '0;
        f.zl = zl;
        f.no = no;
        return f;
    endfunction

    // queue the expected frame for each accepted input beat
    always @(posedge clk)
    begin
        comp_t v [9];
        if (rst_n && in_valid && !in_stall)
        begin
            v = '{x_first, x_second, x_third, y_first, y_second, y_third,
                  z_first, z_second, z_third};
            frames_pending.push_back(build_frame(v));
        end
    end

    // compare each output beat against the oldest expected frame
    always @(posedge clk)
    begin
        frame_t e;
        logic [31:0] got [9];
        bit bad;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{m00, m10, m20, m01, m11, m21, m02, m12, m22};
            if (frames_pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output beat at cycle %0d", cycles);
            end
            else
            begin
                e = frames_pending.pop_front();
                bad = (zero_length !== e.zl) || (not_orthogonal !== e.no);
                for (int i = 0; i < 9; i++)
                    if (got[i] !== e.m[i])
                        bad = 1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at cycle %0d: zl %b/%b no %b/%b (exp/got)",
                                 cycles, e.zl, zero_length, e.no, not_orthogonal);
                        for (int i = 0; i < 9; i++)
                            $display("  m[%0d] exp %h got %h", i, e.m[i], got[i]);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    // output stall: random hold-off per beat, none while no_gaps is set
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 18);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_frame(comp_t v [9]);
        int n;
        n = no_gaps ? 0 : $urandom_range(0, 18);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        x_first  <= v[0]; x_second <= v[1]; x_third <= v[2];
        y_first  <= v[3]; y_second <= v[4]; y_third <= v[5];
        z_first  <= v[6]; z_second <= v[7]; z_third <= v[8];
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (frames_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_DIMENSION: frame_dim   = d[DIM_W-1:0];
            REG_LAST_AXIS: frame_given = d[0];
            REG_ORTH_TOL:  frame_tol   = d[TOL_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_mode(logic [DIM_W-1:0] dim, logic given, logic [TOL_W-1:0] tol);
        wait_idle();
        write_reg(REG_DIMENSION, CFG_DATA_W'(dim));
        write_reg(REG_LAST_AXIS, CFG_DATA_W'(given));
        write_reg(REG_ORTH_TOL, CFG_DATA_W'(tol));
    endtask

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return comp_t'($urandom());
            1: return comp_t'($urandom_range(0, 2 * ONE)) - ONE;
            2: return $urandom_range(0, 1) ? CMAX : CMIN;
            3: return 0;
            4: return $urandom_range(0, 1) ? ONE : -ONE;
            default: return comp_t'($urandom_range(0, 4096)) - 2048;
        endcase
    endfunction

    // half well-formed frames (perpendicular pairs, axis-aligned units), half noise
    function automatic void rand_frame(output comp_t v [9]);
        comp_t a, b, c;
        for (int i = 0; i < 9; i++)
            v[i] = rand_comp();
        case ($urandom_range(0, 3))
            0:
            begin
                a = comp_t'($urandom_range(0, 2 * ONE)) - ONE;
                b = comp_t'($urandom_range(0, 2 * ONE)) - ONE;
                c = comp_t'($urandom_range(0, 2 * ONE)) - ONE;
                v[0:2] = '{a, b, 0};
                v[3:5] = '{-b, a, c};
                v[6:8] = '{comp_t'(longint'(a) * c / ONE), comp_t'(longint'(b) * c / ONE),
                           comp_t'(-(longint'(a) * a + longint'(b) * b) / ONE)};
            end
            1:
            begin
                for (int i = 0; i < 9; i++)
                    v[i] = 0;
                v[0] = $urandom_range(0, 1) ? ONE : -ONE;
                v[4] = $urandom_range(0, 1) ? ONE : -ONE;
                v[8] = $urandom_range(0, 1) ? ONE : -ONE;
            end
            default: ;
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_reset_defaults();
        send_frame('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE});
        send_frame('{0, 0, 0, 0, ONE, 0, 0, 0, 0});
        send_frame('{ONE, 0, 0, 0, 0, 0, 0, 0, 0});
        send_frame('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, 0, 0, 0});
        send_frame('{ONE, 0, 0, ONE, 1, 0, 0, 0, 0});
        send_frame('{CMIN, 0, 0, 0, CMIN, 0, 0, 0, 0});
        send_frame('{1, -1, 1, -1, 1, 1, 0, 0, 0});
    endtask

    task automatic test_two_d();
        set_mode(DIM_2D, 1'b0, TOL_RST);
        send_frame('{ONE, 0, 5, 7, 9, 11, 13, 15, 17});
        send_frame('{CMIN, CMAX, 0, 0, 0, 0, 0, 0, 0});
        send_frame('{0, 0, ONE, ONE, ONE, ONE, ONE, ONE, ONE});
        set_mode(DIM_2D, 1'b1, 31'd0);
        send_frame('{ONE, 0, 0, 0, ONE, 0, 0, 0, 0});
        send_frame('{ONE, 0, 0, 1, CMAX, 0, 0, 0, 0});
        send_frame('{ONE, ONE, 0, CMIN, CMAX, 0, 0, 0, 0});
        send_frame('{0, 0, 0, CMAX, CMIN, 0, 0, 0, 0});
    endtask

    task automatic test_given_z();
        set_mode(DIM_RST, 1'b1, {TOL_W{1'b1}});
        send_frame('{ONE, 0, 0, 0, ONE, 0, CMAX, CMIN, ONE});
        send_frame('{ONE, ONE, 0, -ONE, ONE, 0, 0, 0, ONE});
        set_mode(DIM_ZERO, 1'b1, 31'd0);
        send_frame('{ONE, 0, 0, 0, ONE, 0, 1, 0, ONE});
        send_frame('{ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE});
        set_mode(DIM_ONE, 1'b0, 31'd1000);
        send_frame('{3, 4, 0, -4, 3, 0, 0, 0, 0});
        wait_idle();
        write_reg(REG_UNUSED, {CFG_DATA_W{1'b1}});
        send_frame('{ONE, 2, 0, 0, ONE, 0, 0, 0, 0});
    endtask

    task automatic test_random();
        comp_t v [9];
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: set_mode(DIM_2D, 1'b0, 31'd0);
                1: set_mode(DIM_2D, 1'b1, {TOL_W{1'b1}});
                2: set_mode(DIM_RST, 1'b0, 31'd0);
                3: set_mode(DIM_RST, 1'b1, {TOL_W{1'b1}});
                default: set_mode(DIM_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 1) ? TOL_W'($urandom_range(0, 4096))
                                                       : TOL_W'($urandom()));
            endcase
            for (int k = 0; k < 48; k++)
            begin
                if (k % 16 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                rand_frame(v);
                send_frame(v);
            end
            no_gaps = 0;
        end
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = REG_DIMENSION;
        cfg_data = '0;
        in_valid = 0;
        out_stall = 0;
        {x_first, x_second, x_third, y_first, y_second, y_third} = '0;
        {z_first, z_second, z_third} = '0;
        frame_dim = DIM_RST;
        frame_given = GIVEN_RST;
        frame_tol = TOL_RST;
        mismatches = 0;
        cycles = 0;
        no_gaps = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_two_d();
        test_given_z();
        test_random();
        wait_idle();

        if (mismatches == 0 && frames_pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/ofb_pkg.sv
sv/ofb_norm.sv
sv/ofb_post.sv
sv/orthonormal_frame_builder.sv
tb/sv/tb.sv
